/* hw/rtl/lrpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpd_pkg
// shared types, codes and sizes of the latching relay pulse driver
// ----------------------------------------------------------------------------
package lrpd_pkg;

	// number of relay channels
	localparam int CHANNELS = 2;

	// field widths
	localparam int CHAN_W  = 3;
	localparam int MS_W    = 8;
	localparam int OUT_W   = 2;
	localparam int PHASE_W = 3;
	localparam int MASK_W  = (CHANNELS > OUT_W) ? CHANNELS : OUT_W;

	// register reset values
	localparam logic [MS_W-1:0] ON_PULSE_RST  = MS_W'(15);
	localparam logic [MS_W-1:0] OFF_PULSE_RST = MS_W'(15);

	// operation codes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_TRIGGER = 1'b1;

	// action codes
	localparam logic ACT_OFF = 1'b0;
	localparam logic ACT_ON  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ON_PULSE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_PULSE = 1'b1;

	// channel phases
	localparam logic [PHASE_W-1:0] PH_IDLE_OFF  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_IDLE_ON   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_START_ON  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_WAIT_ON   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_START_OFF = 3'd4;
	localparam logic [PHASE_W-1:0] PH_WAIT_OFF  = 3'd5;

	// one item as seen by every channel
	typedef struct packed {
		logic            fire;
		logic            tick;
		logic            action;
		logic [MS_W-1:0] delay;
		logic [MS_W-1:0] on_pulse;
		logic [MS_W-1:0] off_pulse;
	} lrpd_event_t;

	// per-channel status after the item
	typedef struct packed {
		logic pin0;
		logic pin1;
		logic done;
		logic done_on;
		logic status_on;
		logic armed;
	} lrpd_chan_stat_t;

endpackage

/* hw/rtl/lrpd_channel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpd_channel
// state and next-state logic of one relay channel
// ----------------------------------------------------------------------------
module lrpd_channel
	import lrpd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sel,
	input  lrpd_event_t     ev,
	output lrpd_chan_stat_t stat
);

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [MS_W-1:0]    count_q, count_d, count_dec;
	logic               armed_q, armed_d;
	logic               pin0_q, pin0_d;
	logic               pin1_q, pin1_d;
	logic               done_d, done_on_d;

	assign count_dec = (count_q != '0) ? count_q - MS_W'(1) : '0;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		armed_d   = armed_q;
		pin0_d    = pin0_q;
		pin1_d    = pin1_q;
		done_d    = 1'b0;
		done_on_d = 1'b0;
		if (!ev.tick) begin
			if (sel) begin
				pin0_d  = 1'b0;
				pin1_d  = 1'b0;
				phase_d = (ev.action == ACT_ON) ? PH_START_ON : PH_START_OFF;
				count_d = ev.delay;
				armed_d = 1'b1;
			end
		end else if (armed_q) begin
			count_d = count_dec;
			if (count_dec == '0) begin
				unique case (phase_q)
					PH_IDLE_OFF, PH_IDLE_ON: begin
						pin0_d    = 1'b0;
						pin1_d    = 1'b0;
						armed_d   = 1'b0;
						done_d    = 1'b1;
						done_on_d = (phase_q == PH_IDLE_ON);
					end
					PH_START_ON: begin
						pin0_d  = 1'b0;
						pin1_d  = 1'b1;
						phase_d = PH_WAIT_ON;
						count_d = ev.on_pulse;
					end
					PH_WAIT_ON: begin
						phase_d = PH_IDLE_ON;
					end
					PH_START_OFF: begin
						pin0_d  = 1'b1;
						pin1_d  = 1'b0;
						phase_d = PH_WAIT_OFF;
						count_d = ev.off_pulse;
					end
					PH_WAIT_OFF: begin
						phase_d = PH_IDLE_OFF;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE_OFF;
			count_q <= '0;
			armed_q <= 1'b0;
			pin0_q  <= 1'b0;
			pin1_q  <= 1'b0;
		end else if (ev.fire) begin
			phase_q <= phase_d;
			count_q <= count_d;
			armed_q <= armed_d;
			pin0_q  <= pin0_d;
			pin1_q  <= pin1_d;
		end
	end

	// status after this item, registered by the caller
	assign stat.pin0      = pin0_d;
	assign stat.pin1      = pin1_d;
	assign stat.done      = done_d;
	assign stat.done_on   = done_on_d;
	assign stat.status_on = (phase_d == PH_IDLE_ON) || (phase_d == PH_START_ON)
		|| (phase_d == PH_WAIT_ON);
	assign stat.armed     = armed_d;

endmodule

/* hw/rtl/latching_relay_pulse_driver_unit.sv */
`timescale 1ns / 1ps
// an input is held in the input register stage, its result in the result register
// throughput: one item per cycle unless a waiting result is not taken; every channel
// updates in parallel in one pass. The result register frees the input side, so a
// new transfer is taken while a result waits, as long as the result is taken in the
// same cycle or the slot is free. Reset (arst_n low, asynchronous): all channels
// idle off, pins low, disarmed, both pulse registers 15
// ----------------------------------------------------------------------------
// latching_relay_pulse_driver_unit
// pulse sequencer for a bank of two-input latching relay drivers
// ----------------------------------------------------------------------------
module latching_relay_pulse_driver_unit
	import lrpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MS_W-1:0]      cfg_data,
	// input item channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [CHAN_W-1:0]    channel,
	input  logic                 action,
	input  logic [MS_W-1:0]      delay_ms,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_W-1:0]     pin0_mask,
	output logic [OUT_W-1:0]     pin1_mask,
	output logic [OUT_W-1:0]     done_mask,
	output logic [OUT_W-1:0]     done_on_mask,
	output logic [OUT_W-1:0]     status_on_mask,
	output logic [OUT_W-1:0]     armed_mask
);

	// configuration registers, always ready
	logic [MS_W-1:0] on_pulse_q;
	logic [MS_W-1:0] off_pulse_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_pulse_q  <= ON_PULSE_RST;
			off_pulse_q <= OFF_PULSE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ON_PULSE:  on_pulse_q  <= cfg_data;
				REG_OFF_PULSE: off_pulse_q <= cfg_data;
				default:       on_pulse_q  <= on_pulse_q;
			endcase
		end
	end

	// input register stage
	logic              valid_s1;
	logic              op_s1;
	logic [CHAN_W-1:0] channel_s1;
	logic              action_s1;
	logic [MS_W-1:0]   delay_s1;
	logic              advance;
	logic              out_valid_q;

	// stage 1 moves on when the result slot is empty or is being drained
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1      <= operation;
			channel_s1 <= channel;
			action_s1  <= action;
			delay_s1   <= delay_ms;
		end
	end

	// item broadcast to all channels
	lrpd_event_t ev;

	assign ev.fire      = valid_s1 && advance;
	assign ev.tick      = (op_s1 == OP_TICK);
	assign ev.action    = action_s1;
	assign ev.delay     = delay_s1;
	assign ev.on_pulse  = on_pulse_q;
	assign ev.off_pulse = off_pulse_q;

	lrpd_chan_stat_t     stat [CHANNELS];
	logic [CHANNELS-1:0] pin0_v, pin1_v, done_v, done_on_v, st_on_v, armed_v;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		// a trigger for a channel at or above CHANNELS matches no instance
		lrpd_channel u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.sel    (channel_s1 == CHAN_W'(i)),
			.ev     (ev),
			.stat   (stat[i])
		);
		assign pin0_v[i]    = stat[i].pin0;
		assign pin1_v[i]    = stat[i].pin1;
		assign done_v[i]    = stat[i].done;
		assign done_on_v[i] = stat[i].done_on;
		assign st_on_v[i]   = stat[i].status_on;
		assign armed_v[i]   = stat[i].armed;
	end

	// masks widened or cut to the port width, low channels only
	logic [MASK_W-1:0] pin0_x, pin1_x, done_x, done_on_x, st_on_x, armed_x;

	assign pin0_x    = MASK_W'(pin0_v);
	assign pin1_x    = MASK_W'(pin1_v);
	assign done_x    = MASK_W'(done_v);
	assign done_on_x = MASK_W'(done_on_v);
	assign st_on_x   = MASK_W'(st_on_v);
	assign armed_x   = MASK_W'(armed_v);

	// result register
	logic [OUT_W-1:0] pin0_q, pin1_q, done_q, done_on_q, st_on_q, armed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ev.fire) begin
			pin0_q    <= pin0_x[OUT_W-1:0];
			pin1_q    <= pin1_x[OUT_W-1:0];
			done_q    <= done_x[OUT_W-1:0];
			done_on_q <= done_on_x[OUT_W-1:0];
			st_on_q   <= st_on_x[OUT_W-1:0];
			armed_q   <= armed_x[OUT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign pin0_mask      = pin0_q;
	assign pin1_mask      = pin1_q;
	assign done_mask      = done_q;
	assign done_on_mask   = done_on_q;
	assign status_on_mask = st_on_q;
	assign armed_mask     = armed_q;

endmodule
